// ===== rtl/core/stt_pkg.sv =====
// Shared types, constants and helper functions for the source text tokenizer.
package stt_pkg;

  localparam int NameDepth = 8;
  localparam int NameIdxW  = $clog2(NameDepth);
  localparam int PosW      = 16;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } stt_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  token_type;
    logic [15:0] row;
    logic [15:0] column;
    logic [15:0] length;
    logic [63:0] value;
    logic [2:0]  error_code;
    logic        last_of_run;
  } stt_out_t;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_UNEXPECTED = 3'd0;
  localparam logic [2:0] ERR_STRING     = 3'd1;
  localparam logic [2:0] ERR_COMMENT    = 3'd2;
  localparam logic [2:0] ERR_CHAR       = 3'd3;
  localparam logic [2:0] ERR_DOT        = 3'd4;
  localparam logic [2:0] ERR_NUMBER     = 3'd5;

  localparam logic [5:0] T_IDENT = 6'd16;
  localparam logic [5:0] T_INT   = 6'd29;
  localparam logic [5:0] T_FLOAT = 6'd30;
  localparam logic [5:0] T_CHAR  = 6'd31;
  localparam logic [5:0] T_STR   = 6'd32;
  localparam logic [5:0] T_SLASH = 6'd46;

  typedef enum logic [3:0] {
    M_IDLE, M_COLON, M_BANG, M_LESS, M_GREATER, M_SLASH, M_LINE, M_BLOCK,
    M_STAR, M_CHOPEN, M_CHCLOSE, M_STRING, M_IDENT, M_ZERO, M_NUMBER
  } mode_t;

  typedef enum logic [1:0] {B_DEC, B_HEX, B_BIN} base_t;

  // Keyword lookup: the name bytes packed first character in the low byte.
  function automatic logic [5:0] kw_lookup(input logic [8*NameDepth-1:0] nm,
                                           input logic [15:0] len);
    logic [5:0] t;
    t = T_IDENT;
    case (len)
      16'd2: begin
        case (nm[15:0])
          16'h6669: t = 6'd2;   // if
          16'h726f: t = 6'd15;  // or
          16'h3075: t = 6'd17;  // u0
          16'h3875: t = 6'd18;  // u8
          16'h3869: t = 6'd22;  // i8
          default:  t = T_IDENT;
        endcase
      end
      16'd3: begin
        case (nm[23:0])
          24'h74756d: t = 6'd1;   // mut
          24'h726f66: t = 6'd4;   // for
          24'h646e61: t = 6'd14;  // and
          24'h363175: t = 6'd19;
          24'h323375: t = 6'd20;
          24'h343675: t = 6'd21;
          24'h363169: t = 6'd23;
          24'h323369: t = 6'd24;
          24'h343669: t = 6'd25;
          24'h343666: t = 6'd26;
          default:    t = T_IDENT;
        endcase
      end
      16'd4: begin
        case (nm[31:0])
          32'h636e7566: t = 6'd0;   // func
          32'h65736c65: t = 6'd3;   // else
          32'h65757274: t = 6'd11;  // true
          32'h6c6c756e: t = 6'd13;  // null
          32'h6c6f6f62: t = 6'd27;  // bool
          default:      t = T_IDENT;
        endcase
      end
      16'd5: begin
        case (nm[39:0])
          40'h656c696877: t = 6'd5;   // while
          40'h746e697270: t = 6'd6;   // print
          40'h6b61657262: t = 6'd9;   // break
          40'h65736c6166: t = 6'd12;  // false
          default:        t = T_IDENT;
        endcase
      end
      16'd6: begin
        case (nm[47:0])
          48'h6e7275746572: t = 6'd7;   // return
          48'h676e69727453: t = 6'd28;  // String
          default:          t = T_IDENT;
        endcase
      end
      16'd7: t = (nm[55:0] == 56'h736e7275746572) ? 6'd8 : T_IDENT;
      16'd8: t = (nm[63:0] == 64'h65756e69746e6f63) ? 6'd10 : T_IDENT;
      default: t = T_IDENT;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

endpackage

// ===== rtl/core/stt_core.sv =====
// Lexer state and the single-pass next-state and result logic per byte.
module stt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  stt_pkg::stt_in_t  item,
  output logic [1:0]        res_cnt,
  output stt_pkg::stt_out_t res0,
  output stt_pkg::stt_out_t res1
);
  import stt_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  name_r [NameDepth];
  logic        wr_en;
  logic [NameIdxW-1:0] wr_idx;
  logic        long_r, long_nxt;
  logic [15:0] len_r, len_nxt;
  logic [63:0] acc_r, acc_nxt;
  base_t       base_r, base_nxt;
  logic        dot_r, dot_nxt, esc_r, esc_nxt, halt_r, halt_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] row_r, row_nxt, col_r, col_nxt, srow_r, srow_nxt, scol_r, scol_nxt;

  logic [8*NameDepth-1:0] name_flat;
  always_comb begin
    for (int i = 0; i < NameDepth; i++) name_flat[8*i +: 8] = name_r[i];
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) name_r[wr_idx] <= item.byte_in;
  end

  always_comb begin
    logic [7:0] c;
    logic       redo;
    logic       isdig, isalp, isspc, ishex, ok;
    logic [3:0] d;
    logic [67:0] m10;
    stt_out_t   r;
    mode_t      m;
    c = item.byte_in;
    isdig = (c >= 8'h30) && (c <= 8'h39);
    isalp = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    isspc = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    ishex = isdig || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    mode_nxt = mode_r; long_nxt = long_r; len_nxt = len_r; acc_nxt = acc_r;
    base_nxt = base_r; dot_nxt = dot_r; esc_nxt = esc_r; halt_nxt = halt_r;
    held_nxt = held_r; row_nxt = row_r; col_nxt = col_r;
    srow_nxt = srow_r; scol_nxt = scol_r;
    wr_en = 1'b0; wr_idx = len_r[NameIdxW-1:0];
    res_cnt = 2'd0; res0 = '0; res1 = '0; redo = 1'b0;
    r = '0; m = mode_r; d = '0; m10 = '0; ok = 1'b0;

    // Pending token of the current mode (used on a terminating byte or end).
    case (mode_r)
      M_COLON:   begin r.token_type = 6'd40; r.length = 16'd1; end
      M_BANG:    begin r.token_type = 6'd43; r.length = 16'd1; end
      M_LESS:    begin r.token_type = 6'd52; r.length = 16'd1; end
      M_GREATER: begin r.token_type = 6'd54; r.length = 16'd1; end
      M_SLASH:   begin r.token_type = T_SLASH; r.length = 16'd1; end
      M_IDENT: begin
        r.token_type = long_r ? T_IDENT : kw_lookup(name_flat, len_r);
        r.length = len_r;
      end
      default: begin
        r.length = len_r;
        if (dot_r) r.token_type = T_FLOAT;
        else begin r.token_type = T_INT; r.value = acc_r; end
      end
    endcase
    r.kind = KIND_TOKEN; r.row = srow_r; r.column = scol_r;

    if (!halt_r) begin
      if (item.end_of_input) begin
        case (mode_r)
          M_COLON, M_BANG, M_LESS, M_GREATER, M_SLASH, M_IDENT: begin
            res0 = r; res_cnt = 2'd1;
          end
          M_BLOCK, M_STAR: begin
            res0.kind = KIND_ERROR; res0.error_code = ERR_COMMENT; res_cnt = 2'd1;
            halt_nxt = 1'b1;
          end
          M_CHOPEN, M_CHCLOSE: begin
            res0.kind = KIND_ERROR; res0.error_code = ERR_CHAR; res_cnt = 2'd1;
            halt_nxt = 1'b1;
          end
          M_STRING: begin
            res0.kind = KIND_ERROR; res0.error_code = ERR_STRING; res_cnt = 2'd1;
            halt_nxt = 1'b1;
          end
          M_ZERO, M_NUMBER: begin
            res_cnt = 2'd1;
            if (dot_r && held_r == 8'h2e) begin
              res0.kind = KIND_ERROR; res0.error_code = ERR_DOT; halt_nxt = 1'b1;
            end else if (base_r == B_HEX && len_r == 16'd2) begin
              res0.kind = KIND_ERROR; res0.error_code = ERR_NUMBER; halt_nxt = 1'b1;
            end else res0 = r;
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
        if (!halt_nxt) begin
          esc_nxt = 1'b0; row_nxt = '0; col_nxt = '0;
        end
      end else begin
        case (mode_r)
          M_COLON, M_BANG, M_LESS, M_GREATER: begin
            if (c == 8'h3d) begin
              case (mode_r)
                M_COLON: r.token_type = 6'd50;
                M_BANG:  r.token_type = 6'd51;
                M_LESS:  r.token_type = 6'd53;
                default: r.token_type = 6'd55;
              endcase
              r.length = 16'd2;
              res0 = r; res_cnt = 2'd1; col_nxt = sat_add(col_r, 16'd2);
              mode_nxt = M_IDLE;
            end else begin
              res0 = r; res_cnt = 2'd1; col_nxt = sat_add(col_r, 16'd1); redo = 1'b1;
            end
          end
          M_SLASH: begin
            if (c == 8'h2f) mode_nxt = M_LINE;
            else if (c == 8'h2a) begin
              col_nxt = sat_add(col_r, 16'd2); mode_nxt = M_BLOCK;
            end else begin
              res0 = r; res_cnt = 2'd1; col_nxt = sat_add(col_r, 16'd1); redo = 1'b1;
            end
          end
          M_LINE: begin
            if (c == 8'h0a) begin
              row_nxt = sat_add(row_r, 16'd1); col_nxt = '0; mode_nxt = M_IDLE;
            end
          end
          M_BLOCK, M_STAR: begin
            if (mode_r == M_STAR && c == 8'h2f) begin
              col_nxt = sat_add(col_r, 16'd2); mode_nxt = M_IDLE;
            end else begin
              // A star that is not followed by a slash counts one column.
              col_nxt = (mode_r == M_STAR) ? sat_add(col_r, 16'd1) : col_r;
              mode_nxt = M_BLOCK;
              if (c == 8'h2a) mode_nxt = M_STAR;
              else if (c == 8'h0a) begin
                row_nxt = sat_add(row_r, 16'd1); col_nxt = '0;
              end else col_nxt = sat_add(col_nxt, 16'd1);
            end
          end
          M_CHOPEN: begin
            if (c == 8'h5c) begin
              res0.kind = KIND_ERROR; res0.error_code = ERR_CHAR; res_cnt = 2'd1;
              halt_nxt = 1'b1; mode_nxt = M_IDLE;
            end else begin
              held_nxt = c; mode_nxt = M_CHCLOSE;
            end
          end
          M_CHCLOSE: begin
            res_cnt = 2'd1; mode_nxt = M_IDLE;
            if (c == 8'h27) begin
              res0 = r; res0.token_type = T_CHAR; res0.length = 16'd3;
              res0.value = {56'd0, held_r}; col_nxt = sat_add(col_r, 16'd3);
            end else begin
              res0 = '0; res0.kind = KIND_ERROR; res0.error_code = ERR_CHAR;
              halt_nxt = 1'b1;
            end
          end
          M_STRING: begin
            if (!esc_r && c == 8'h5c) esc_nxt = 1'b1;
            else if (!esc_r && c == 8'h22) begin
              res0 = r; res0.token_type = T_STR; res0.length = sat_add(len_r, 16'd1);
              res0.value = '0; res_cnt = 2'd1;
              col_nxt = sat_add(col_r, res0.length); mode_nxt = M_IDLE;
            end else begin
              esc_nxt = 1'b0;
              res0.kind = KIND_BYTE; res0.token_type = T_STR;
              res0.row = srow_r; res0.column = scol_r;
              res0.value = {56'd0, c};
              if (esc_r) begin
                case (c)
                  8'h6e: res0.value = 64'd10;
                  8'h74: res0.value = 64'd9;
                  8'h72: res0.value = 64'd13;
                  8'h30: res0.value = 64'd0;
                  default: ;
                endcase
              end
              res_cnt = 2'd1; len_nxt = sat_add(len_r, 16'd1);
            end
          end
          M_IDENT: begin
            if (isalp || isdig || c == 8'h5f) begin
              if (len_r < 16'(NameDepth)) wr_en = 1'b1;
              else long_nxt = 1'b1;
              len_nxt = sat_add(len_r, 16'd1);
            end else begin
              res0 = r; res_cnt = 2'd1; col_nxt = sat_add(col_r, len_r); redo = 1'b1;
            end
          end
          M_ZERO, M_NUMBER: begin
            if (mode_r == M_ZERO && (c == 8'h78 || c == 8'h58 || c == 8'h62 ||
                                      c == 8'h42)) begin
              base_nxt = ((c | 8'h20) == 8'h78) ? B_HEX : B_BIN;
              held_nxt = c; len_nxt = sat_add(len_r, 16'd1); mode_nxt = M_NUMBER;
            end else begin
              mode_nxt = M_NUMBER;
              case (base_r)
                B_HEX:   ok = ishex;
                B_BIN:   ok = (c == 8'h30) || (c == 8'h31);
                default: ok = isdig || (c == 8'h2e && !dot_r);
              endcase
              if (!ok) begin
                res_cnt = 2'd1;
                if (dot_r && held_r == 8'h2e) begin
                  res0.kind = KIND_ERROR; res0.error_code = ERR_DOT;
                  halt_nxt = 1'b1; mode_nxt = M_IDLE;
                end else if (base_r == B_HEX && len_r == 16'd2) begin
                  res0.kind = KIND_ERROR; res0.error_code = ERR_NUMBER;
                  halt_nxt = 1'b1; mode_nxt = M_IDLE;
                end else begin
                  res0 = r; col_nxt = sat_add(col_r, len_r); redo = 1'b1;
                end
              end else begin
                d = isdig ? c[3:0] : 4'(c[3:0] + 4'd9);
                if (base_r == B_HEX)
                  acc_nxt = (acc_r[63:60] != 4'd0) ? '1 : {acc_r[59:0], d};
                else if (base_r == B_BIN)
                  acc_nxt = acc_r[63] ? '1 : {acc_r[62:0], c[0]};
                else if (c == 8'h2e) dot_nxt = 1'b1;
                else if (!dot_r) begin
                  m10 = {4'd0, acc_r} * 68'd10 + {64'd0, c[3:0]};
                  acc_nxt = (m10[67:64] != 4'd0) ? '1 : m10[63:0];
                end
                held_nxt = c; len_nxt = sat_add(len_r, 16'd1);
              end
            end
          end
          default: redo = 1'b1;
        endcase

        // Idle handling of the byte, possibly after a pending token.
        if (redo) begin
          m = M_IDLE;
          srow_nxt = row_nxt; scol_nxt = col_nxt;
          r = '0; r.kind = KIND_TOKEN; r.row = row_nxt; r.column = col_nxt;
          r.length = 16'd1;
          ok = 1'b1;
          case (c)
            8'h28: r.token_type = 6'd33;
            8'h29: r.token_type = 6'd34;
            8'h7b: r.token_type = 6'd35;
            8'h7d: r.token_type = 6'd36;
            8'h5b: r.token_type = 6'd37;
            8'h5d: r.token_type = 6'd38;
            8'h2c: r.token_type = 6'd39;
            8'h3b: r.token_type = 6'd41;
            8'h7e: r.token_type = 6'd42;
            8'h2b: r.token_type = 6'd44;
            8'h2d: r.token_type = 6'd45;
            8'h2a: r.token_type = 6'd47;
            8'h3d: r.token_type = 6'd48;
            8'h25: r.token_type = 6'd49;
            default: ok = 1'b0;
          endcase
          if (isspc) begin
            if (c == 8'h0a) begin
              row_nxt = sat_add(row_nxt, 16'd1); col_nxt = '0;
            end else col_nxt = sat_add(col_nxt, 16'd1);
          end else if (ok) begin
            col_nxt = sat_add(col_nxt, 16'd1);
            if (res_cnt == 2'd0) begin res0 = r; res_cnt = 2'd1; end
            else begin res1 = r; res_cnt = 2'd2; end
          end else begin
            case (c)
              8'h3a: m = M_COLON;
              8'h21: m = M_BANG;
              8'h3c: m = M_LESS;
              8'h3e: m = M_GREATER;
              8'h2f: m = M_SLASH;
              8'h27: m = M_CHOPEN;
              8'h22: begin m = M_STRING; len_nxt = 16'd1; esc_nxt = 1'b0; end
              default: begin
                if (isdig) begin
                  acc_nxt = {60'd0, c[3:0]}; len_nxt = 16'd1; base_nxt = B_DEC;
                  dot_nxt = 1'b0; held_nxt = c;
                  m = (c == 8'h30) ? M_ZERO : M_NUMBER;
                end else if (isalp || c == 8'h5f) begin
                  wr_en = 1'b1; wr_idx = '0; len_nxt = 16'd1; long_nxt = 1'b0;
                  m = M_IDENT;
                end else begin
                  r = '0; r.kind = KIND_ERROR; r.error_code = ERR_UNEXPECTED;
                  halt_nxt = 1'b1;
                  if (res_cnt == 2'd0) begin res0 = r; res_cnt = 2'd1; end
                  else begin res1 = r; res_cnt = 2'd2; end
                end
              end
            endcase
          end
          mode_nxt = m;
        end
      end
    end
    if (res_cnt == 2'd1) res0.last_of_run = 1'b1;
    if (res_cnt == 2'd2) res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; long_r <= 1'b0; len_r <= '0; acc_r <= '0; base_r <= B_DEC;
      dot_r <= 1'b0; esc_r <= 1'b0; halt_r <= 1'b0; held_r <= '0;
      row_r <= '0; col_r <= '0; srow_r <= '0; scol_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt; long_r <= long_nxt; len_r <= len_nxt; acc_r <= acc_nxt;
      base_r <= base_nxt; dot_r <= dot_nxt; esc_r <= esc_nxt; halt_r <= halt_nxt;
      held_r <= held_nxt; row_r <= row_nxt; col_r <= col_nxt;
      srow_r <= srow_nxt; scol_r <= scol_nxt;
    end
  end
endmodule

// ===== rtl/core/stt_outq.sv =====
// Small result queue: up to two results per byte, one out per cycle unless stalled.
module stt_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        push_cnt,
  input  stt_pkg::stt_out_t push0,
  input  stt_pkg::stt_out_t push1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  // Four-entry circular queue; a byte is taken only when two entries are free.
  stt_out_t    q_r [4];
  logic [1:0]  rd_r, wr_r;
  logic [2:0]  cnt_r;
  logic        pop;
  logic [1:0]  n;

  assign n = push ? push_cnt : 2'd0;
  assign pop = (cnt_r != 3'd0) && !out_stall;
  assign out_valid = cnt_r != 3'd0;
  assign out_data = q_r[rd_r];
  assign room = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (n != 2'd0) q_r[wr_r] <= push0;
    if (n == 2'd2) q_r[2'(wr_r + 2'd1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (pop) rd_r <= 2'(rd_r + 2'd1);
      wr_r <= 2'(wr_r + n);
      cnt_r <= 3'(cnt_r + {1'b0, n} - {2'b0, pop});
    end
  end
endmodule

// ===== rtl/core/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: input register, lexer core, result queue.
//
//  channel | direction | payload
//  in_     | input     | stt_in_t: byte_in, end_of_input
//  out_    | output    | stt_out_t: token or string byte or error, with position
//
// One byte is accepted per cycle; the lexer core updates its state in a single
// pass and yields zero, one or two results, which a four-entry queue drains at
// one per cycle (no out_stall), so sustained rate is one item a cycle unless items
// give two results. in_stall rises when the queue cannot take two more results.
// Synchronous active-low reset returns the lexer to idle at row and column zero.
module source_text_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::stt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  stt_in_t    item_r;
  logic       item_vld_r;
  logic       room, step;
  logic [1:0] res_cnt;
  stt_out_t   res0, res1;

  assign step = item_vld_r && room;
  assign in_stall = item_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) item_vld_r <= 1'b0;
    else if (!in_stall) item_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) item_r <= in_data;
  end

  stt_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .item(item_r),
    .res_cnt(res_cnt), .res0(res0), .res1(res1)
  );

  stt_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(step), .push_cnt(res_cnt),
    .push0(res0), .push1(res1), .room(room),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
